[hdl/motor_command_frame_encoder_defines.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the motor command frame encoder
// Concurrent assertion wrappers; they expand to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef MOTOR_COMMAND_FRAME_ENCODER_DEFINES_SVH
`define MOTOR_COMMAND_FRAME_ENCODER_DEFINES_SVH

`ifndef SYNTH
// Checked only outside reset
`define MCFE_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("mcfe assertion failed");
// Checked at every edge, reset included
`define MCFE_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("mcfe assertion failed");
`else
`define MCFE_ASSERT(label, clk, rstn, prop)
`define MCFE_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hdl/mcfe_pkg.sv]
// ---------------------------------------------------------------------------
// mcfe_pkg
// Types, constants and the CRC-16/MODBUS byte update for the frame encoder.
// ---------------------------------------------------------------------------
package mcfe_pkg;

    // Drive command codes; codes above stop are handled as stop
    typedef enum logic [2:0] {
        CMD_FORWARD  = 3'd0,
        CMD_BACKWARD = 3'd1,
        CMD_RIGHT    = 3'd2,
        CMD_LEFT     = 3'd3,
        CMD_STOP     = 3'd4
    } cmd_e;

    // Input transfer payload
    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] speed;
    } cmd_in_t;

    // Output transfer payload
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } frame_out_t;

    // Item as it travels down the CRC pipeline
    typedef struct packed {
        logic [7:0]  speed;
        logic [7:0]  dir;
        logic [15:0] crc;
    } work_t;

    localparam logic [7:0]  FRAME_START   = 8'hFF;
    localparam logic [7:0]  FRAME_LENCODE = 8'h07;
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;

    localparam logic [7:0] DIR_FORWARD  = 8'd80;
    localparam logic [7:0] DIR_BACKWARD = 8'd0;
    localparam logic [7:0] DIR_RIGHT    = 8'd64;
    localparam logic [7:0] DIR_LEFT     = 8'd16;
    localparam logic [7:0] DIR_STOP     = 8'd0;

    // Byte positions within one frame
    localparam int unsigned FRAME_LEN = 9;
    localparam logic [3:0] POS_START   = 4'd0;
    localparam logic [3:0] POS_LENCODE = 4'd1;
    localparam logic [3:0] POS_LSPEED  = 4'd2;
    localparam logic [3:0] POS_LPAD    = 4'd3;
    localparam logic [3:0] POS_RSPEED  = 4'd4;
    localparam logic [3:0] POS_RPAD    = 4'd5;
    localparam logic [3:0] POS_DIR     = 4'd6;
    localparam logic [3:0] POS_CRC_LO  = 4'd7;
    localparam logic [3:0] POS_CRC_HI  = 4'd8;

    // Pipeline stages that each fold one frame byte into the CRC
    localparam int unsigned NUM_CRC_STAGES = 5;

    // Fold one byte into a reflected CRC-16, one bit per step
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // CRC after the fixed length code byte
    localparam logic [15:0] CRC_AFTER_LEN = crc_byte(CRC_INIT, FRAME_LENCODE);

endpackage

[hdl/motor_command_frame_encoder.sv]
// ---------------------------------------------------------------------------
// motor_command_frame_encoder
// Encode drive commands into nine-byte frames closed by a CRC-16/MODBUS.
// ---------------------------------------------------------------------------
//  channel  | ports                      | payload
//  ---------+----------------------------+------------------------------------
//  command  | s_valid, s_ready, s_data   | cmd_in_t    {cmd, speed}
//  frame    | m_valid, m_ready, m_data   | frame_out_t {frame_byte, last_byte}
//
//  Each command gives nine frame byte transfers, one per cycle at best, and
//  the byte serializer takes the next command only as the last byte leaves.
//  A command passes a decode register and five CRC stages (one byte each)
//  before its first byte shows.
//  Reset is synchronous, active low, and empties every stage.
//  Stalls on the frame side back up through the stages; nothing is lost.
// ---------------------------------------------------------------------------
module motor_command_frame_encoder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mcfe_pkg::cmd_in_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mcfe_pkg::frame_out_t m_data
);
    import mcfe_pkg::*;

    logic  dec_valid_reg;
    logic  dec_valid_next;
    work_t dec_item_reg;
    work_t dec_item_next;

    logic  stg_valid [0:NUM_CRC_STAGES];
    logic  stg_ready [0:NUM_CRC_STAGES];
    work_t stg_item  [0:NUM_CRC_STAGES];

    // Decode command into speed and direction byte
    always_comb begin
        dec_item_next     = '0;
        dec_item_next.crc = CRC_AFTER_LEN;
        unique case (s_data.cmd)
            CMD_FORWARD: begin
                dec_item_next.speed = s_data.speed;
                dec_item_next.dir   = DIR_FORWARD;
            end
            CMD_BACKWARD: begin
                dec_item_next.speed = s_data.speed;
                dec_item_next.dir   = DIR_BACKWARD;
            end
            CMD_RIGHT: begin
                dec_item_next.speed = s_data.speed;
                dec_item_next.dir   = DIR_RIGHT;
            end
            CMD_LEFT: begin
                dec_item_next.speed = s_data.speed;
                dec_item_next.dir   = DIR_LEFT;
            end
            default: begin
                // stop and unused codes: zero speed
                dec_item_next.speed = 8'h00;
                dec_item_next.dir   = DIR_STOP;
            end
        endcase
    end

    assign s_ready        = !dec_valid_reg || stg_ready[0];
    assign dec_valid_next = s_ready ? s_valid : dec_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dec_valid_reg <= 1'b0;
        end else begin
            dec_valid_reg <= dec_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            dec_item_reg <= dec_item_next;
        end
    end

    assign stg_valid[0] = dec_valid_reg;
    assign stg_item[0]  = dec_item_reg;

    // Fold left speed, pad, right speed, pad and direction, one per stage
    for (genvar k = 0; k < NUM_CRC_STAGES; k++) begin : g_crc
        logic [7:0] feed;
        if (k == NUM_CRC_STAGES - 1) begin : g_dir
            assign feed = stg_item[k].dir;
        end else if ((k % 2) == 0) begin : g_speed
            assign feed = stg_item[k].speed;
        end else begin : g_pad
            assign feed = 8'h00;
        end

        mcfe_crc_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_item   (stg_item[k]),
            .feed_byte (feed),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_item  (stg_item[k+1])
        );
    end

    mcfe_serializer u_ser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (stg_valid[NUM_CRC_STAGES]),
        .in_ready (stg_ready[NUM_CRC_STAGES]),
        .in_item  (stg_item[NUM_CRC_STAGES]),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

[hdl/mcfe_crc_stage.sv]
// ---------------------------------------------------------------------------
// mcfe_crc_stage
// One pipeline stage: fold one byte into the running CRC and register it.
// ---------------------------------------------------------------------------
module mcfe_crc_stage (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mcfe_pkg::work_t in_item,
    input  logic [7:0]      feed_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output mcfe_pkg::work_t out_item
);
    import mcfe_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    work_t item_reg;
    work_t item_next;

    // Advance when this stage is empty or its content moves on
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        item_next  = item_reg;
        if (in_ready) begin
            valid_next    = in_valid;
            item_next     = in_item;
            item_next.crc = crc_byte(in_item.crc, feed_byte);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

[hdl/mcfe_serializer.sv]
// ---------------------------------------------------------------------------
// mcfe_serializer
// Hold one finished item and send its nine frame bytes, one per transfer.
// ---------------------------------------------------------------------------
module mcfe_serializer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mcfe_pkg::work_t      in_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mcfe_pkg::frame_out_t m_data
);
    import mcfe_pkg::*;

    `include "motor_command_frame_encoder_defines.svh"

    logic       busy_reg;
    logic       busy_next;
    logic [3:0] pos_reg;
    logic [3:0] pos_next;
    work_t      item_reg;
    work_t      item_next;
    logic       at_last;
    logic       out_xfer;

    assign at_last  = (pos_reg == POS_CRC_HI);
    assign out_xfer = busy_reg && m_ready;
    // Take the next item when empty or when the final byte leaves
    assign in_ready = !busy_reg || (m_ready && at_last);

    // Byte position and item hold
    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        item_next = item_reg;
        if (in_ready) begin
            busy_next = in_valid;
            pos_next  = POS_START;
            item_next = in_item;
        end else if (out_xfer) begin
            pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_START;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    // Select the frame byte for the current position and flag the final one
    always_comb begin
        m_data.last_byte = at_last;
        unique case (pos_reg)
            POS_START:   m_data.frame_byte = FRAME_START;
            POS_LENCODE: m_data.frame_byte = FRAME_LENCODE;
            POS_LSPEED:  m_data.frame_byte = item_reg.speed;
            POS_LPAD:    m_data.frame_byte = 8'h00;
            POS_RSPEED:  m_data.frame_byte = item_reg.speed;
            POS_RPAD:    m_data.frame_byte = 8'h00;
            POS_DIR:     m_data.frame_byte = item_reg.dir;
            POS_CRC_LO:  m_data.frame_byte = item_reg.crc[7:0];
            POS_CRC_HI:  m_data.frame_byte = item_reg.crc[15:8];
            default:     m_data.frame_byte = 8'h00;
        endcase
    end

    assign m_valid = busy_reg;

    // Position never runs past the final byte
    `MCFE_ASSERT_ALWAYS(a_pos_range, aclk, !aresetn || pos_reg <= POS_CRC_HI)
    // A frame never breaks off before its final byte
    `MCFE_ASSERT(a_frame_whole, aclk, aresetn, out_xfer && !at_last |=> busy_reg)
    // A stalled byte keeps its position
    `MCFE_ASSERT(a_stall_hold, aclk, aresetn, busy_reg && !m_ready |=> $stable(pos_reg))
    // Every frame starts at the start byte
    `MCFE_ASSERT(a_start_pos, aclk, aresetn, in_ready && in_valid |=> pos_reg == POS_START)

endmodule
